### sv/multi_tap_presence_detector_defines.svh
// ----------------------------------------------------------------------------
// Multi-tap presence detector: assertion macros
// Concurrent checks on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_TAP_PRESENCE_DETECTOR_DEFINES_SVH
`define MULTI_TAP_PRESENCE_DETECTOR_DEFINES_SVH

`ifndef SYNTH
`define MTPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MTPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MTPD_ASSERT(lbl, prop, msg)
`define MTPD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### sv/mtpd_pkg.sv
// ----------------------------------------------------------------------------
// Multi-tap presence detector: package
// Shared types, register indexes, codes and limits.
// ----------------------------------------------------------------------------
package mtpd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int SRC_W      = 2;
  localparam int REQ_TAPS_W = 3;
  localparam int WINDOW_W   = 13;
  localparam int TIMEOUT_W  = 15;
  localparam int AGE_W      = 15;
  localparam int SINCE_W    = 13;
  localparam int TAPS_OUT_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_SOURCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIN_ACTIVE_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS_REQUIRED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GESTURE_WINDOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_TIMEOUT = 3'd4;

  localparam logic [SRC_W-1:0] SRC_NONE   = 2'd0;
  localparam logic [SRC_W-1:0] SRC_BUTTON = 2'd1;
  localparam logic [SRC_W-1:0] SRC_PIN    = 2'd2;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam logic [SRC_W-1:0]      RST_SIGNAL_SOURCE   = 2'd1;
  localparam logic                  RST_PIN_ACTIVE_LOW  = 1'b1;
  localparam logic [REQ_TAPS_W-1:0] RST_TAPS_REQUIRED   = 3'd1;
  localparam logic [WINDOW_W-1:0]   RST_GESTURE_WINDOW  = 13'd1000;
  localparam logic [TIMEOUT_W-1:0]  RST_REQUEST_TIMEOUT = 15'd30000;

  localparam logic [WINDOW_W-1:0]  WINDOW_LO  = 13'd100;
  localparam logic [WINDOW_W-1:0]  WINDOW_HI  = 13'd5000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_LO = 15'd500;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_HI = 15'd30000;

  typedef enum logic [1:0] {
    STATUS_IDLE      = 2'd0,
    STATUS_WAITING   = 2'd1,
    STATUS_CONFIRMED = 2'd2,
    STATUS_TIMEOUT   = 2'd3
  } status_e;

  typedef struct packed {
    logic [SRC_W-1:0]      signal_source;
    logic                  pin_active_low;
    logic [REQ_TAPS_W-1:0] taps_required;
    logic [WINDOW_W-1:0]   window;
    logic [TIMEOUT_W-1:0]  timeout;
  } cfg_t;

  typedef struct packed {
    status_e               status;
    logic                  done_res;
    logic [TAPS_OUT_W-1:0] taps_counted;
  } result_t;

endpackage

### sv/mtpd_cfg.sv
// ----------------------------------------------------------------------------
// Multi-tap presence detector: configuration registers
// Write-only register file; window and timeout leave it clamped.
// ----------------------------------------------------------------------------
module mtpd_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mtpd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mtpd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output mtpd_pkg::cfg_t                   cfg_o
);

  logic [mtpd_pkg::SRC_W-1:0]      source_q;
  logic                            pin_low_q;
  logic [mtpd_pkg::REQ_TAPS_W-1:0] taps_q;
  logic [mtpd_pkg::WINDOW_W-1:0]   window_q;
  logic [mtpd_pkg::TIMEOUT_W-1:0]  timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_q  <= mtpd_pkg::RST_SIGNAL_SOURCE;
      pin_low_q <= mtpd_pkg::RST_PIN_ACTIVE_LOW;
      taps_q    <= mtpd_pkg::RST_TAPS_REQUIRED;
      window_q  <= mtpd_pkg::RST_GESTURE_WINDOW;
      timeout_q <= mtpd_pkg::RST_REQUEST_TIMEOUT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mtpd_pkg::REG_SIGNAL_SOURCE:   source_q  <= cfg_data_i[mtpd_pkg::SRC_W-1:0];
        mtpd_pkg::REG_PIN_ACTIVE_LOW:  pin_low_q <= cfg_data_i[0];
        mtpd_pkg::REG_TAPS_REQUIRED:   taps_q    <= cfg_data_i[mtpd_pkg::REQ_TAPS_W-1:0];
        mtpd_pkg::REG_GESTURE_WINDOW:  window_q  <= cfg_data_i[mtpd_pkg::WINDOW_W-1:0];
        mtpd_pkg::REG_REQUEST_TIMEOUT: timeout_q <= cfg_data_i[mtpd_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.signal_source  = source_q;
    cfg_o.pin_active_low = pin_low_q;
    cfg_o.taps_required  = taps_q;
    if (window_q < mtpd_pkg::WINDOW_LO) begin
      cfg_o.window = mtpd_pkg::WINDOW_LO;
    end else if (window_q > mtpd_pkg::WINDOW_HI) begin
      cfg_o.window = mtpd_pkg::WINDOW_HI;
    end else begin
      cfg_o.window = window_q;
    end
    if (timeout_q < mtpd_pkg::TIMEOUT_LO) begin
      cfg_o.timeout = mtpd_pkg::TIMEOUT_LO;
    end else if (timeout_q > mtpd_pkg::TIMEOUT_HI) begin
      cfg_o.timeout = mtpd_pkg::TIMEOUT_HI;
    end else begin
      cfg_o.timeout = timeout_q;
    end
  end

endmodule

### sv/mtpd_core.sv
// ----------------------------------------------------------------------------
// Multi-tap presence detector: request state and tap logic
// Combinational update of the request state for one command, registered on step_i.
// ----------------------------------------------------------------------------
`include "multi_tap_presence_detector_defines.svh"

module mtpd_core #(
  parameter int MAX_TAPS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              cmd_i,
  input  logic              button_level_i,
  input  logic              pin_level_i,
  input  mtpd_pkg::cfg_t    cfg_i,
  output mtpd_pkg::result_t res_o
);

  localparam int TW = $clog2(MAX_TAPS + 1);
  localparam int CW = (TW > mtpd_pkg::REQ_TAPS_W) ? TW : mtpd_pkg::REQ_TAPS_W;

  logic                         active_q, active_d;
  logic                         prev_q, prev_d;
  logic [TW-1:0]                tally_q, tally_d;
  logic [mtpd_pkg::AGE_W-1:0]   age_q, age_d;
  logic [mtpd_pkg::SINCE_W-1:0] since_q, since_d;

  logic          pressed;
  logic [CW-1:0] req_ext;
  logic [TW-1:0] need;

  always_comb begin
    case (cfg_i.signal_source)
      mtpd_pkg::SRC_NONE:   pressed = 1'b0;
      mtpd_pkg::SRC_BUTTON: pressed = button_level_i;
      default:              pressed = pin_level_i ^ cfg_i.pin_active_low;
    endcase
  end

  always_comb begin
    req_ext = CW'(cfg_i.taps_required);
    if (req_ext == '0) begin
      need = TW'(1);
    end else if (req_ext > CW'(MAX_TAPS)) begin
      need = TW'(MAX_TAPS);
    end else begin
      need = TW'(req_ext);
    end
  end

  always_comb begin
    active_d = active_q;
    prev_d   = prev_q;
    tally_d  = tally_q;
    age_d    = age_q;
    since_d  = since_q;
    res_o.status       = mtpd_pkg::STATUS_IDLE;
    res_o.done_res     = 1'b0;
    res_o.taps_counted = '0;
    if (cmd_i == mtpd_pkg::CMD_START) begin
      tally_d = '0;
      age_d   = '0;
      since_d = '0;
      if (cfg_i.signal_source == mtpd_pkg::SRC_NONE) begin
        active_d       = 1'b0;
        prev_d         = 1'b0;
        res_o.status   = mtpd_pkg::STATUS_CONFIRMED;
        res_o.done_res = 1'b1;
      end else begin
        active_d     = 1'b1;
        prev_d       = pressed;
        res_o.status = mtpd_pkg::STATUS_WAITING;
      end
    end else if (!active_q) begin
      res_o.status = mtpd_pkg::STATUS_IDLE;
    end else if (age_q >= cfg_i.timeout) begin
      active_d           = 1'b0;
      tally_d            = '0;
      res_o.status       = mtpd_pkg::STATUS_TIMEOUT;
      res_o.done_res     = 1'b1;
      res_o.taps_counted = mtpd_pkg::TAPS_OUT_W'(tally_q);
    end else begin
      res_o.status = mtpd_pkg::STATUS_WAITING;
      if (pressed && !prev_q) begin
        if (need == TW'(1)) begin
          active_d           = 1'b0;
          tally_d            = '0;
          res_o.status       = mtpd_pkg::STATUS_CONFIRMED;
          res_o.done_res     = 1'b1;
          res_o.taps_counted = mtpd_pkg::TAPS_OUT_W'(1);
        end else if (tally_q == '0 || since_q > cfg_i.window) begin
          tally_d = TW'(1);
          since_d = '0;
        end else begin
          if (tally_q < TW'(MAX_TAPS)) begin
            tally_d = tally_q + TW'(1);
          end
          if (tally_d >= need) begin
            active_d           = 1'b0;
            res_o.status       = mtpd_pkg::STATUS_CONFIRMED;
            res_o.done_res     = 1'b1;
            res_o.taps_counted = mtpd_pkg::TAPS_OUT_W'(tally_d);
            tally_d            = '0;
          end
        end
      end
      if (!res_o.done_res) begin
        if (tally_d != '0 && since_d > cfg_i.window) begin
          tally_d = '0;
        end
        prev_d = pressed;
        if (age_q != '1) begin
          age_d = age_q + mtpd_pkg::AGE_W'(1);
        end
        if (since_d != '1) begin
          since_d = since_d + mtpd_pkg::SINCE_W'(1);
        end
        res_o.taps_counted = mtpd_pkg::TAPS_OUT_W'(tally_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      prev_q   <= 1'b0;
      tally_q  <= '0;
      age_q    <= '0;
      since_q  <= '0;
    end else if (step_i) begin
      active_q <= active_d;
      prev_q   <= prev_d;
      tally_q  <= tally_d;
      age_q    <= age_d;
      since_q  <= since_d;
    end
  end

  `MTPD_ASSERT(a_done_status, !res_o.done_res || res_o.status == mtpd_pkg::STATUS_CONFIRMED || res_o.status == mtpd_pkg::STATUS_TIMEOUT, "done without final status")
  `MTPD_ASSERT_NEXT(a_done_closes, step_i && res_o.done_res, !active_q && tally_q == '0, "request left open after end")
  `MTPD_ASSERT(a_tally_sat, tally_q <= TW'(MAX_TAPS), "tap tally above limit")

endmodule

### sv/multi_tap_presence_detector.sv
// ----------------------------------------------------------------------------
// Multi-tap presence detector: top level
// Request/tick front end with input register and result register.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while the output is not stalled, and
// returns exactly one result per request via the input register and the
// result register, with the combinational request state update between
// them. Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i
// by the user while no request is in flight; the block does not enforce it.
`include "multi_tap_presence_detector_defines.svh"

module multi_tap_presence_detector #(
  parameter int MAX_TAPS = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mtpd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mtpd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 cmd_i,
  input  logic                                 button_level_i,
  input  logic                                 pin_level_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           status_o,
  output logic                                 done_res_o,
  output logic [mtpd_pkg::TAPS_OUT_W-1:0]      taps_counted_o
);

  mtpd_pkg::cfg_t    cfg;
  mtpd_pkg::result_t res;
  mtpd_pkg::result_t res_q;

  logic in_valid_q;
  logic cmd_q, button_q, pin_q;
  logic out_valid_q;
  logic adv;

  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q    <= cmd_i;
      button_q <= button_level_i;
      pin_q    <= pin_level_i;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  mtpd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mtpd_core #(
    .MAX_TAPS (MAX_TAPS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (adv),
    .cmd_i          (cmd_q),
    .button_level_i (button_q),
    .pin_level_i    (pin_q),
    .cfg_i          (cfg),
    .res_o          (res)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_q.status;
  assign done_res_o     = res_q.done_res;
  assign taps_counted_o = res_q.taps_counted;

  `MTPD_ASSERT_NEXT(a_in_hold, in_valid_q && !adv, in_valid_q && $stable(cmd_q), "held request lost")
  `MTPD_ASSERT_NEXT(a_out_load, adv, out_valid_q, "result not loaded")
  `MTPD_ASSERT_NEXT(a_out_stall, out_valid_q && !out_ready_i, out_valid_q && $stable(res_q), "stalled result changed")

endmodule
